### rtl/bba_pkg.sv
// bba_pkg: request and status codes, field widths and default sizes for the
// bitmap block allocator. No dependencies.
package bba_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int unsigned NUM_FILES_DEF      = 32;
  localparam int unsigned WORDS_PER_FILE_DEF = 256;
  localparam int unsigned BITS_PER_WORD_DEF  = 32;

  // port field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned FILE_W   = 5;
  localparam int unsigned BLOCK_W  = 13;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_FIRST = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NEXT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_FILE      = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NONE_ALLOC    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_INVALID_BLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL          = 3'd4;
  localparam logic [STATUS_W-1:0] STS_ALREADY_FREED = 3'd5;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_REM   = 6'b001000,
    ST_RD    = 6'b010000,
    ST_EVAL  = 6'b100000
  } bba_state_t;

endpackage

### rtl/bba_lsb.sv
// bba_lsb: finds the lowest set bit of one bitmap word.
// Standalone; no package needed.
module bba_lsb #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);

  localparam int unsigned IW = $clog2(W);

  logic [W-1:0] iso;

  // keep only the lowest set bit
  assign iso   = vec & (~vec + W'(1));
  assign found = |vec;

  // one-hot to binary: each index bit is an or over the positions that carry it
  always_comb begin
    idx = '0;
    for (int k = 0; k < IW; k++) begin
      for (int j = 0; j < W; j++) begin
        if (((j >> k) & 1) == 1) begin
          idx[k] = idx[k] | iso[j];
        end
      end
    end
  end

endmodule

### rtl/bitmap_block_allocator.sv
// bitmap_block_allocator: per-file allocation bitmaps in one synchronous memory,
// with first-fit search one word per cycle. Uses bba_pkg and bba_lsb.
//
//   channel | ports                                              | direction
//   input   | start, busy, in_req_type, in_file_id,              | in (busy out)
//           | in_block_index, in_load_data                       |
//   result  | out_valid, out_status, out_found_block             | out
//
// A transfer is taken when start is high and busy is low. A bad file or an
// unused request code answers in the next cycle; next from the last block is
// answered from the remainder state. Others pass the divide, remainder, read and
// evaluate states, first, next and allocate reading up to WORDS_PER_FILE bitmap
// words, check, free and load reading one word.
// After reset a clearing pass writes zero to all NUM_FILES * WORDS_PER_FILE
// words, one per cycle, with busy high. out_valid is a one-cycle strobe that
// cannot be held off.
module bitmap_block_allocator #(
  parameter int unsigned NUM_FILES      = bba_pkg::NUM_FILES_DEF,
  parameter int unsigned WORDS_PER_FILE = bba_pkg::WORDS_PER_FILE_DEF,
  parameter int unsigned BITS_PER_WORD  = bba_pkg::BITS_PER_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bba_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bba_pkg::FILE_W-1:0]    in_file_id,
  input  logic [bba_pkg::BLOCK_W-1:0]   in_block_index,
  input  logic [bba_pkg::DATA_W-1:0]    in_load_data,
  output logic                          out_valid,
  output logic [bba_pkg::STATUS_W-1:0]  out_status,
  output logic [bba_pkg::BLOCK_W-1:0]   out_found_block
);

  localparam int unsigned BW    = BITS_PER_WORD;
  localparam int unsigned BLKW  = bba_pkg::BLOCK_W;
  localparam int unsigned DEPTH = NUM_FILES * WORDS_PER_FILE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = BLKW + 1;               // holds block_index + 1
  localparam int unsigned QMAX  = (1 << BLKW) / BW;
  localparam int unsigned QW    = $clog2(QMAX + 1);
  localparam int unsigned IW    = $clog2(BW);
  localparam int unsigned BBW   = $clog2(WORDS_PER_FILE * BW + 1);
  localparam int unsigned WCW   = (WORDS_PER_FILE > 1) ? $clog2(WORDS_PER_FILE) : 1;
  // reciprocal for the division by the word width, exact for all TW-bit values
  localparam int unsigned DIV_S = TW + $clog2(BW);
  localparam int unsigned DIV_M = ((1 << DIV_S) + BW - 1) / BW;
  localparam int unsigned MW    = TW + 1;

  // state and control
  bba_pkg::bba_state_t state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // request payload and working registers
  logic [bba_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [bba_pkg::FILE_W-1:0]   file_r, file_nxt;
  logic [BLKW-1:0]              blk_r, blk_nxt;
  logic [bba_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic [TW-1:0]                tgt_r, tgt_nxt;
  logic [QW-1:0]                q_r, q_nxt;
  logic [AW-1:0]                fbase_r, fbase_nxt;
  logic [IW-1:0]                r_r, r_nxt;
  logic [BBW-1:0]               bb_r, bb_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [AW-1:0]                cur_addr_r, cur_addr_nxt;
  logic [WCW-1:0]               word_r, word_nxt;
  logic                         first_r, first_nxt;
  logic [bba_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BLKW-1:0]              out_found_r, out_found_nxt;

  // memory
  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] rdata_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [BW-1:0] wd;

  // datapath
  logic [TW+MW-1:0] qprod;
  logic [TW-1:0]    qbw;
  logic             in_range;
  logic [BW-1:0]    scan_vec;
  logic             lsb_found;
  logic [IW-1:0]    lsb_idx;
  logic             sel_bit;
  logic             last_word;

  assign qprod     = (TW + MW)'(tgt_r) * (TW + MW)'(DIV_M);
  assign qbw       = TW'(TW'(q_r) * TW'(BW));
  assign in_range  = 32'(q_r) < 32'(WORDS_PER_FILE);
  assign sel_bit   = rdata_r[r_r];
  assign last_word = (word_r == WCW'(WORDS_PER_FILE - 1));

  // allocate looks for a clear bit; the first word of next skips bits below the start
  always_comb begin
    scan_vec = (req_r == bba_pkg::REQ_ALLOC) ? ~rdata_r : rdata_r;
    if (first_r) begin
      scan_vec = scan_vec & ({BW{1'b1}} << r_r);
    end
  end

  bba_lsb #(.W(BW)) u_lsb (
    .vec   (scan_vec),
    .found (lsb_found),
    .idx   (lsb_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = 1'b0;
    req_nxt        = req_r;
    file_nxt       = file_r;
    blk_nxt        = blk_r;
    data_nxt       = data_r;
    tgt_nxt        = tgt_r;
    q_nxt          = q_r;
    fbase_nxt      = fbase_r;
    r_nxt          = r_r;
    bb_nxt         = bb_r;
    addr_nxt       = addr_r;
    cur_addr_nxt   = cur_addr_r;
    word_nxt       = word_r;
    first_nxt      = first_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    we             = 1'b0;
    wa             = cur_addr_r;
    wd             = rdata_r;

    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = bba_pkg::ST_IDLE;
        end
      end

      bba_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt  = in_req_type;
          file_nxt = in_file_id;
          blk_nxt  = in_block_index;
          data_nxt = in_load_data;
          priority if (32'(in_file_id) >= 32'(NUM_FILES)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bba_pkg::STS_BAD_FILE;
            out_found_nxt  = '0;
          end else if (in_req_type == bba_pkg::REQ_FIRST ||
                       in_req_type == bba_pkg::REQ_ALLOC) begin
            tgt_nxt   = '0;
            state_nxt = bba_pkg::ST_DIV;
          end else if (in_req_type == bba_pkg::REQ_NEXT) begin
            tgt_nxt   = TW'(in_block_index) + TW'(1);
            state_nxt = bba_pkg::ST_DIV;
          end else if (in_req_type == bba_pkg::REQ_CHECK ||
                       in_req_type == bba_pkg::REQ_FREE ||
                       in_req_type == bba_pkg::REQ_LOAD) begin
            tgt_nxt   = TW'(in_block_index);
            state_nxt = bba_pkg::ST_DIV;
          end else begin
            // unused request codes
            out_valid_nxt  = 1'b1;
            out_status_nxt = bba_pkg::STS_OK;
            out_found_nxt  = '0;
          end
        end
      end

      bba_pkg::ST_DIV: begin
        q_nxt     = QW'(qprod >> DIV_S);
        fbase_nxt = AW'(AW'(file_r) * AW'(WORDS_PER_FILE));
        state_nxt = bba_pkg::ST_REM;
      end

      bba_pkg::ST_REM: begin
        r_nxt     = IW'(tgt_r - qbw);
        bb_nxt    = BBW'(qbw);
        addr_nxt  = fbase_r + AW'(q_r);
        word_nxt  = WCW'(q_r);
        first_nxt = 1'b1;
        if (in_range) begin
          state_nxt = bba_pkg::ST_RD;
        end else begin
          // start word past the end of the file, also next from the last block
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STS_INVALID_BLOCK;
          out_found_nxt  = '0;
          state_nxt      = bba_pkg::ST_IDLE;
        end
      end

      bba_pkg::ST_RD: begin
        cur_addr_nxt = addr_r;
        addr_nxt     = addr_r + AW'(1);
        state_nxt    = bba_pkg::ST_EVAL;
      end

      bba_pkg::ST_EVAL: begin
        unique case (req_r)
          bba_pkg::REQ_FIRST, bba_pkg::REQ_NEXT, bba_pkg::REQ_ALLOC: begin
            if (lsb_found) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bba_pkg::STS_OK;
              out_found_nxt  = BLKW'(bb_r + BBW'(lsb_idx));
              state_nxt      = bba_pkg::ST_IDLE;
              if (req_r == bba_pkg::REQ_ALLOC) begin
                we = 1'b1;
                wd = rdata_r | (BW'(1) << lsb_idx);
              end
            end else if (last_word) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = '0;
              state_nxt     = bba_pkg::ST_IDLE;
              priority case (req_r)
                bba_pkg::REQ_FIRST: out_status_nxt = bba_pkg::STS_NONE_ALLOC;
                bba_pkg::REQ_NEXT:  out_status_nxt = bba_pkg::STS_INVALID_BLOCK;
                default:            out_status_nxt = bba_pkg::STS_FULL;
              endcase
            end else begin
              // move on to the word whose read is already in flight
              cur_addr_nxt = addr_r;
              addr_nxt     = addr_r + AW'(1);
              word_nxt     = word_r + WCW'(1);
              bb_nxt       = bb_r + BBW'(BW);
              first_nxt    = 1'b0;
            end
          end

          bba_pkg::REQ_CHECK: begin
            out_valid_nxt = 1'b1;
            state_nxt     = bba_pkg::ST_IDLE;
            if (sel_bit) begin
              out_status_nxt = bba_pkg::STS_OK;
              out_found_nxt  = blk_r;
            end else begin
              out_status_nxt = bba_pkg::STS_INVALID_BLOCK;
              out_found_nxt  = '0;
            end
          end

          bba_pkg::REQ_FREE: begin
            out_valid_nxt = 1'b1;
            state_nxt     = bba_pkg::ST_IDLE;
            if (sel_bit) begin
              we             = 1'b1;
              wd             = rdata_r & ~(BW'(1) << r_r);
              out_status_nxt = bba_pkg::STS_OK;
              out_found_nxt  = blk_r;
            end else begin
              out_status_nxt = bba_pkg::STS_ALREADY_FREED;
              out_found_nxt  = '0;
            end
          end

          bba_pkg::REQ_LOAD: begin
            we             = 1'b1;
            wd             = BW'(data_r);
            out_valid_nxt  = 1'b1;
            out_status_nxt = bba_pkg::STS_OK;
            out_found_nxt  = BLKW'(bb_r);
            state_nxt      = bba_pkg::ST_IDLE;
          end

          default: begin
            state_nxt = bba_pkg::ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = bba_pkg::ST_IDLE;
      end
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    file_r       <= file_nxt;
    blk_r        <= blk_nxt;
    data_r       <= data_nxt;
    tgt_r        <= tgt_nxt;
    q_r          <= q_nxt;
    fbase_r      <= fbase_nxt;
    r_r          <= r_nxt;
    bb_r         <= bb_nxt;
    addr_r       <= addr_nxt;
    cur_addr_r   <= cur_addr_nxt;
    word_r       <= word_nxt;
    first_r      <= first_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign busy            = (state_r != bba_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_block = out_found_r;

endmodule

### tb/bitmap_block_allocator_tb.sv
// bitmap_block_allocator_tb: self-checking bench for the bitmap block allocator. It keeps
// a shadow copy of every file's allocation bitmap, predicts each answer on transfer and
// compares with the result strobe. Needs bba_pkg and the allocator RTL.
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int NFILES       = NUM_FILES_DEF;
  localparam int WPF          = WORDS_PER_FILE_DEF;
  localparam int BPW          = BITS_PER_WORD_DEF;
  localparam int BLOCKS       = WPF * BPW;
  localparam int WORK_ITEMS   = 1150;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = WPF + 8;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int MAX_REPORTS  = 10;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] blk;
    logic [DATA_W-1:0]  data;
  } request_t;

  typedef struct packed {
    request_t            cause;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  block;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [FILE_W-1:0]  in_file_id = '0;
  logic [BLOCK_W-1:0] in_block_index = '0;
  logic [DATA_W-1:0]  in_load_data = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [BLOCK_W-1:0]  out_found_block;

  bit [BPW-1:0] shadow_map [NFILES][WPF];
  request_t     requests_todo[$];
  answer_t      answers_due[$];
  int n_total = 0;
  int n_work = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_faults = 0;
  int idle_left = 0;
  bit calm = 1'b0;
  int status_seen [8];

  bitmap_block_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_file_id      (in_file_id),
    .in_block_index  (in_block_index),
    .in_load_data    (in_load_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_block (out_found_block)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // lowest block at or above from whose bit equals want, BLOCKS if none
  function automatic int scan_map(int f, int from, bit want);
    for (int b = from; b < BLOCKS; b++) begin
      if (shadow_map[f][b / BPW][b % BPW] == want) return b;
    end
    return BLOCKS;
  endfunction

  // works out the answer to one request and applies it to the shadow bitmaps
  function automatic answer_t bitmap_answer(request_t r);
    answer_t a;
    int f;
    int idx;
    int w;
    int b;
    a.cause  = r;
    a.status = STS_OK;
    a.block  = '0;
    f   = int'(r.file);
    idx = int'(r.blk);
    w   = idx / BPW;
    if (f >= NFILES) begin
      a.status = STS_BAD_FILE;
      return a;
    end
    case (r.req)
      REQ_FIRST: begin
        b = scan_map(f, 0, 1'b1);
        if (b >= BLOCKS) a.status = STS_NONE_ALLOC;
        else a.block = b[BLOCK_W-1:0];
      end
      REQ_NEXT: begin
        b = BLOCKS;
        if (idx + 1 < BLOCKS) b = scan_map(f, idx + 1, 1'b1);
        if (b >= BLOCKS) a.status = STS_INVALID_BLOCK;
        else a.block = b[BLOCK_W-1:0];
      end
      REQ_CHECK: begin
        if (w >= WPF || !shadow_map[f][w][idx % BPW]) a.status = STS_INVALID_BLOCK;
        else a.block = r.blk;
      end
      REQ_ALLOC: begin
        b = scan_map(f, 0, 1'b0);
        if (b >= BLOCKS) begin
          a.status = STS_FULL;
        end else begin
          shadow_map[f][b / BPW][b % BPW] = 1'b1;
          a.block = b[BLOCK_W-1:0];
        end
      end
      REQ_FREE: begin
        if (w >= WPF) begin
          a.status = STS_INVALID_BLOCK;
        end else if (!shadow_map[f][w][idx % BPW]) begin
          a.status = STS_ALREADY_FREED;
        end else begin
          shadow_map[f][w][idx % BPW] = 1'b0;
          a.block = r.blk;
        end
      end
      REQ_LOAD: begin
        if (w >= WPF) begin
          a.status = STS_INVALID_BLOCK;
        end else begin
          shadow_map[f][w] = r.data[BPW-1:0];
          b = idx - idx % BPW;
          a.block = b[BLOCK_W-1:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic add_request(logic [REQ_W-1:0] req, int file, int blk, logic [DATA_W-1:0] data);
    request_t r;
    r.req  = req;
    r.file = file[FILE_W-1:0];
    r.blk  = blk[BLOCK_W-1:0];
    r.data = data;
    requests_todo.push_back(r);
    if (req <= REQ_LOAD) n_work++;
  endtask

  // mostly a handful of busy files so their bitmaps fill up
  function automatic int pick_file();
    int hot [5] = '{0, 1, 2, 3, 31};
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, NFILES - 1);
    return hot[$urandom_range(0, 4)];
  endfunction

  // driver
  always @(posedge clk) begin : drive
    request_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        nxt = {in_req_type, in_file_id, in_block_index, in_load_data};
        answers_due.push_back(bitmap_answer(nxt));
        n_accepted++;
        if ($urandom_range(0, 47) == 0) calm = !calm;
        if (!calm && requests_todo.size() >= TAIL_ITEMS && $urandom_range(0, 2) == 0)
          idle_left = $urandom_range(1, 13);
      end
      if (start && busy) begin
        // hold the request until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (requests_todo.size() > 0) begin
        nxt = requests_todo.pop_front();
        start          <= 1'b1;
        in_req_type    <= nxt.req;
        in_file_id     <= nxt.file;
        in_block_index <= nxt.blk;
        in_load_data   <= nxt.data;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    answer_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (answers_due.size() == 0) begin
        n_faults++;
        if (n_faults <= MAX_REPORTS)
          $display("unexpected result: status %0d block %0d", out_status, out_found_block);
      end else begin
        e = answers_due.pop_front();
        n_checked++;
        status_seen[out_status]++;
        if (out_status !== e.status || out_found_block !== e.block) begin
          n_faults++;
          if (n_faults <= MAX_REPORTS) begin
            $display("mismatch: req %0d file %0d blk %0d data %h",
                     e.cause.req, e.cause.file, e.cause.blk, e.cause.data);
            $display("  expected status %0d block %0d, got status %0d block %0d",
                     e.status, e.block, out_status, out_found_block);
          end
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d answers outstanding", answers_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int f;
    int w;
    int b;
    int hole;
    int fills;
    logic [DATA_W-1:0] d;
    fills = 0;

    // directed: empty file, first allocations, both ends of the block range
    add_request(REQ_FIRST, 0, 0, '0);
    add_request(REQ_NEXT, 0, 0, '0);
    add_request(REQ_CHECK, 0, 0, '0);
    add_request(REQ_FREE, 0, 0, '0);
    add_request(REQ_ALLOC, 0, BLOCKS - 1, '1);
    add_request(REQ_ALLOC, 0, 0, '0);
    add_request(REQ_FIRST, 0, 0, '0);
    add_request(REQ_NEXT, 0, 0, '0);
    add_request(REQ_NEXT, 0, BLOCKS - 1, '0);
    add_request(REQ_CHECK, 0, 1, '0);
    add_request(REQ_FREE, 0, 0, '0);
    add_request(REQ_ALLOC, 0, 0, '0);
    add_request(REQ_LOAD, NFILES - 1, BLOCKS - 1, '1);
    add_request(REQ_FIRST, NFILES - 1, 0, '0);
    add_request(REQ_NEXT, NFILES - 1, BLOCKS - 2, '0);
    add_request(REQ_NEXT, NFILES - 1, BLOCKS - 1, '0);
    add_request(REQ_CHECK, NFILES - 1, BLOCKS - 1, '0);
    add_request(REQ_FREE, NFILES - 1, BLOCKS - 1, '0);
    add_request(REQ_LOAD, NFILES - 1, BPW + 5, 32'h8000_0001);
    add_request(REQ_NEXT, NFILES - 1, BPW, '0);
    add_request(REQ_LOAD, NFILES - 1, 0, '0);
    add_request(REQ_SPARE_LO, 5, BLOCKS - 1, '1);
    add_request(REQ_SPARE_HI, NFILES - 1, 0, '0);
    add_request(REQ_LOAD, NFILES - 1, BLOCKS - BPW, '0);

    while (n_work < WORK_ITEMS) begin
      f = pick_file();
      case ($urandom_range(0, 9))
        0, 1: begin
          // noise: anything the fields allow
          repeat ($urandom_range(1, 8))
            add_request(REQ_W'($urandom_range(0, REQ_SPARE_HI)),
                        $urandom_range(0, NFILES - 1),
                        $urandom_range(0, BLOCKS - 1), $urandom);
        end
        2, 3, 4: begin
          // allocate then free and check low blocks
          repeat ($urandom_range(1, 6))
            add_request(REQ_ALLOC, f, $urandom_range(0, BLOCKS - 1), $urandom);
          repeat ($urandom_range(1, 4)) begin
            b = $urandom_range(0, 15);
            add_request(REQ_FREE, f, b, $urandom);
            add_request(REQ_CHECK, f, b, $urandom);
          end
        end
        5, 6, 7: begin
          // load one word, then poke blocks inside it
          w = $urandom_range(0, WPF - 1);
          case ($urandom_range(0, 3))
            0: d = '0;
            1: d = '1;
            2: d = $urandom & $urandom & $urandom;
            default: d = $urandom;
          endcase
          add_request(REQ_LOAD, f, w * BPW + $urandom_range(0, BPW - 1), d);
          repeat ($urandom_range(2, 6)) begin
            b = w * BPW + $urandom_range(0, BPW - 1);
            case ($urandom_range(0, 3))
              0: add_request(REQ_CHECK, f, b, $urandom);
              1: add_request(REQ_FREE, f, b, $urandom);
              2: add_request(REQ_NEXT, f, b, $urandom);
              default: add_request(REQ_ALLOC, f, b, $urandom);
            endcase
          end
          add_request(REQ_FIRST, f, $urandom_range(0, BLOCKS - 1), $urandom);
        end
        8: begin
          // walk the allocated blocks from assorted places
          add_request(REQ_FIRST, f, 0, '0);
          repeat ($urandom_range(2, 6)) begin
            b = ($urandom_range(0, 3) == 0) ? BLOCKS - $urandom_range(1, 2)
                                            : $urandom_range(0, BLOCKS - 1);
            add_request(REQ_NEXT, f, b, $urandom);
          end
        end
        default: begin
          if (fills < 2 && n_work > 150) begin
            // fill a file leaving one hole, then run it to full
            fills++;
            hole = $urandom_range(0, BLOCKS - 1);
            for (int i = 0; i < WPF; i++) begin
              d = '1;
              if (i == hole / BPW) d[hole % BPW] = 1'b0;
              add_request(REQ_LOAD, f, i * BPW + $urandom_range(0, BPW - 1), d);
            end
            add_request(REQ_ALLOC, f, 0, '0);
            add_request(REQ_ALLOC, f, 0, '0);
            add_request(REQ_FIRST, f, 0, '0);
            b = $urandom_range(0, BLOCKS - 1);
            add_request(REQ_FREE, f, b, '0);
            add_request(REQ_CHECK, f, b, '0);
            add_request(REQ_NEXT, f, (b == 0) ? 0 : b - 1, '0);
            add_request(REQ_ALLOC, f, 0, '0);
            add_request(REQ_FREE, f, hole, '0);
            add_request(REQ_FREE, f, hole, '0);
            add_request(REQ_ALLOC, f, 0, '0);
          end else begin
            add_request(REQ_ALLOC, f, $urandom_range(0, BLOCKS - 1), $urandom);
            add_request(REQ_FIRST, f, $urandom_range(0, BLOCKS - 1), $urandom);
          end
        end
      endcase
    end
    n_total = requests_todo.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    n_faults += answers_due.size();
    $display("%0d requests sent, %0d answers checked, %0d faults", n_total, n_checked, n_faults);
    $display("answers by status: ok %0d, none %0d, invalid %0d, full %0d, freed twice %0d",
             status_seen[STS_OK], status_seen[STS_NONE_ALLOC], status_seen[STS_INVALID_BLOCK],
             status_seen[STS_FULL], status_seen[STS_ALREADY_FREED]);
    if (n_faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bba_pkg.sv
rtl/bba_lsb.sv
rtl/bitmap_block_allocator.sv
tb/bitmap_block_allocator_tb.sv
